FILE: rtl/ufrm_pkg.sv
// ----------------------------------------------------------------------------
// ufrm_pkg
// Shared types and constants for the UART FIFO register model.
// ----------------------------------------------------------------------------
package ufrm_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BAUD_W     = 16;

    localparam logic [CFG_ADDR_W-3:0] REG_BAUD   = '0;
    localparam logic [BAUD_W-1:0]     BAUD_RESET = 16'd1;

    typedef enum logic [1:0] {
        MODE_LINE_RX   = 2'd0,
        MODE_CPU_READ  = 2'd1,
        MODE_CPU_WRITE = 2'd2,
        MODE_LINE_TX   = 2'd3
    } ufrm_mode_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic not_empty_next;
        logic not_full_next;
    } ufrm_fifo_stat_t;

endpackage

FILE: rtl/ufrm_fifo.sv
// ----------------------------------------------------------------------------
// ufrm_fifo
// Byte FIFO with registered head read; one push or one pop per cycle.
// ----------------------------------------------------------------------------
module ufrm_fifo #(
    parameter int DEPTH = ufrm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    pop,
    input  logic [7:0]              data,
    output logic [7:0]              head,
    output ufrm_pkg::ufrm_fifo_stat_t stat
);
    import ufrm_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    logic [7:0]        mem [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        head_reg;
    logic              do_push, do_pop;

    assign do_push = push && (fill_reg != FILL_FULL);
    assign do_pop  = pop && (fill_reg != '0);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    // head tracks the entry at the read pointer; bypass a write into it
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= data;
        if (do_push && (wr_ptr_reg == rd_ptr_next))
            head_reg <= data;
        else
            head_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    assign head                = head_reg;
    assign stat.full           = (fill_reg == FILL_FULL);
    assign stat.empty          = (fill_reg == '0);
    assign stat.not_empty_next = (fill_next != '0);
    assign stat.not_full_next  = (fill_next != FILL_FULL);

endmodule

FILE: rtl/ufrm_regs.sv
// ----------------------------------------------------------------------------
// ufrm_regs
// APB configuration register file holding the baud divisor.
// ----------------------------------------------------------------------------
module ufrm_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ufrm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ufrm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ufrm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [ufrm_pkg::BAUD_W-1:0]     baud_div
);
    import ufrm_pkg::*;

    logic [BAUD_W-1:0] baud_reg;
    logic              sel_baud;

    assign sel_baud = (paddr[CFG_ADDR_W-1:2] == REG_BAUD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            baud_reg <= BAUD_RESET;
        else if (psel && penable && pwrite && pready && sel_baud)
            baud_reg <= pwdata[BAUD_W-1:0];
    end

    always_comb
    begin
        if (sel_baud)
            prdata = {{(CFG_DATA_W - BAUD_W){1'b0}}, baud_reg};
        else
            prdata = '0;
    end

    assign pready   = 1'b1;
    assign baud_div = baud_reg;

endmodule

FILE: rtl/uart_fifo_register_model_top.sv
// ----------------------------------------------------------------------------
// uart_fifo_register_model_top
// UART register model with receive and transmit byte FIFOs.
//
// Input channel (in_valid / in_stall) carries one operation per item: mode
// selects line receive, CPU read, CPU write or line transmit; data_in is the
// byte pushed. Each item yields exactly one result item on the output
// channel (out_valid / out_stall) with outcome, popped byte and status view.
// Items pass an input register, then the FIFO update logic, into the result
// register, which raises out_valid. One item per cycle is sustained while
// the receiver does not stall. When the receiver stalls, the result register
// holds; the input register still takes an item if it is empty, after which
// in_stall rises.
// Reset clears both FIFOs, the overflow mark and all valids; the baud
// divisor resets to 1. The APB port is to write the divisor only while idle;
// the block does not enforce this. pready is always high.
// ----------------------------------------------------------------------------
module uart_fifo_register_model_top #(
    parameter int FIFO_DEPTH = ufrm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [7:0]                      data_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            op_failed,
    output logic [7:0]                      byte_out,
    output logic                            rx_ready,
    output logic                            tx_ready,
    output logic                            rx_overflow,
    output logic [7:0]                      data_view,
    output logic [ufrm_pkg::BAUD_W-1:0]     baud_view,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ufrm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ufrm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ufrm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ufrm_pkg::*;

    logic              in_valid_reg;
    ufrm_mode_t        mode_reg;
    logic [7:0]        data_reg;
    logic              advance;

    logic              out_valid_reg;
    logic              op_failed_reg, op_failed_next;
    logic [7:0]        byte_out_reg, byte_out_next;
    logic              rx_ready_reg;
    logic              tx_ready_reg;
    logic              overflow_reg, overflow_next;
    logic [BAUD_W-1:0] baud_view_reg;

    logic [BAUD_W-1:0] baud_div;
    logic              rx_push, rx_pop, tx_push, tx_pop;
    logic [7:0]        rx_head, tx_head;
    ufrm_fifo_stat_t   rx_stat, tx_stat;
    logic              ok;

    ufrm_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .baud_div (baud_div)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            mode_reg <= ufrm_mode_t'(mode);
            data_reg <= data_in;
        end
    end

    assign rx_push = advance && (mode_reg == MODE_LINE_RX);
    assign rx_pop  = advance && (mode_reg == MODE_CPU_READ);
    assign tx_push = advance && (mode_reg == MODE_CPU_WRITE);
    assign tx_pop  = advance && (mode_reg == MODE_LINE_TX);

    ufrm_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rx_push),
        .pop   (rx_pop),
        .data  (data_reg),
        .head  (rx_head),
        .stat  (rx_stat)
    );

    ufrm_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tx_push),
        .pop   (tx_pop),
        .data  (data_reg),
        .head  (tx_head),
        .stat  (tx_stat)
    );

    always_comb
    begin
        case (mode_reg)
            MODE_LINE_RX:   ok = !rx_stat.full;
            MODE_CPU_READ:  ok = !rx_stat.empty;
            MODE_CPU_WRITE: ok = !tx_stat.full;
            MODE_LINE_TX:   ok = !tx_stat.empty;
            default:        ok = 1'b0;
        endcase
    end

    always_comb
    begin
        op_failed_next = !ok;
        byte_out_next  = 8'd0;
        if (ok && (mode_reg == MODE_CPU_READ))
            byte_out_next = rx_head;
        else if (ok && (mode_reg == MODE_LINE_TX))
            byte_out_next = tx_head;
        if (ok)
            overflow_next = 1'b0;
        else if (mode_reg == MODE_LINE_RX)
            overflow_next = 1'b1;
        else
            overflow_next = overflow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                overflow_reg  <= overflow_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_failed_reg <= op_failed_next;
            byte_out_reg  <= byte_out_next;
            rx_ready_reg  <= rx_stat.not_empty_next;
            tx_ready_reg  <= tx_stat.not_full_next;
            baud_view_reg <= baud_div;
        end
    end

    assign out_valid   = out_valid_reg;
    assign op_failed   = op_failed_reg;
    assign byte_out    = byte_out_reg;
    assign rx_ready    = rx_ready_reg;
    assign tx_ready    = tx_ready_reg;
    assign rx_overflow = overflow_reg;
    assign data_view   = rx_ready_reg ? rx_head : 8'd0;
    assign baud_view   = baud_view_reg;

    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed item produced no result");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a held item");

    a_rx_full_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rx_push && rx_stat.full |=> rx_overflow && op_failed)
        else $error("receive into full FIFO did not flag overflow");

    a_single_fifo_op: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({rx_push, rx_pop, tx_push, tx_pop}) <= 1)
        else $error("more than one FIFO operation in a cycle");

endmodule
